FILE: src/mgim_pkg.sv
// ----------------------------------------------------------------------------
// mgim_pkg: shared types and constants for the multigrid index map
// Widths, command and register codes, queue entry and result layouts, and the
// small lookup functions used by the front part.
// ----------------------------------------------------------------------------
package mgim_pkg;

    localparam int MAX_FINE_DIM = 1024;
    localparam int MAX_GRIDS    = 8;
    localparam int MAX_PROCS    = 256;

    localparam int DIM_W    = $clog2(MAX_FINE_DIM);
    localparam int SIZE_W   = DIM_W + 1;
    localparam int FACTOR_W = 4;
    localparam int GRIDS_W  = 4;
    localparam int GID_W    = 6;
    localparam int PROCS_W  = $clog2(MAX_PROCS) + 1;
    localparam int REM_W    = PROCS_W - 1;
    localparam int CNT_W    = 21;
    localparam int K_W      = (MAX_GRIDS > 1) ? $clog2(MAX_GRIDS) : 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SIZE_W;

    // Fixed-point reciprocal of the coarsening factor. With this many fraction
    // bits the quotient of any value below 2^SIZE_W is exact.
    localparam int RECIP_FRAC = SIZE_W + FACTOR_W;
    localparam int RECIP_W    = RECIP_FRAC;
    localparam int RECIP_ONE  = 1 << RECIP_FRAC;

    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_DATA_W = ((2 * DIM_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * DIM_W + GID_W + CNT_W + PROCS_W + CNT_W;
    localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_POINT = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR = 3'd0,
        CFG_ROWS   = 3'd1,
        CFG_COLS   = 3'd2,
        CFG_GRIDS  = 3'd3,
        CFG_GID    = 3'd4,
        CFG_PROCS  = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic [SIZE_W-1:0]   rows;
        logic [SIZE_W-1:0]   cols;
        logic [GRIDS_W-1:0]  grids;
        logic [GID_W-1:0]    gid;
        logic [PROCS_W-1:0]  procs;
    } t_cfg;

    // One queue entry: a start command or a fine point, with the settings
    // that were in force when it was taken.
    typedef struct packed {
        logic                start;
        logic [SIZE_W-1:0]   r1;
        logic [SIZE_W-1:0]   c1;
        logic [CNT_W-1:0]    total;
        logic [RECIP_W-1:0]  recip;
        logic [K_W-1:0]      glast;
        logic [GID_W-1:0]    gid;
        logic [PROCS_W-1:0]  procs;
    } t_item;

    typedef struct packed {
        logic [DIM_W-1:0]   grid_row;
        logic [DIM_W-1:0]   grid_col;
        logic [GID_W-1:0]   grid_number;
        logic [CNT_W-1:0]   global_index;
        logic               boundary_valid;
        logic [PROCS_W-1:0] boundary_rank;
        logic [CNT_W-1:0]   boundary_value;
        logic               last;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] d);
        return (d > SIZE_W'(MAX_FINE_DIM)) ? SIZE_W'(MAX_FINE_DIM) : d;
    endfunction

    function automatic logic [PROCS_W-1:0] eff_procs(input logic [PROCS_W-1:0] p);
        logic [PROCS_W-1:0] res;
        res = p;
        if (p == '0) begin
            res = PROCS_W'(1);
        end else if (p > PROCS_W'(MAX_PROCS)) begin
            res = PROCS_W'(MAX_PROCS);
        end
        return res;
    endfunction

    // Index of the last grid to visit, after clamping the grid count.
    function automatic logic [K_W-1:0] eff_glast(input logic [GRIDS_W-1:0] g);
        logic [K_W-1:0] res;
        if (g == '0) begin
            res = '0;
        end else if (g > GRIDS_W'(MAX_GRIDS)) begin
            res = K_W'(MAX_GRIDS - 1);
        end else begin
            res = K_W'(g - GRIDS_W'(1));
        end
        return res;
    endfunction

    // Rounded-up reciprocal; factors below two behave as two.
    function automatic logic [RECIP_W-1:0] factor_recip(input logic [FACTOR_W-1:0] f);
        logic [RECIP_W-1:0] res;
        unique case (f) inside
            4'd0, 4'd1, 4'd2: res = RECIP_W'(RECIP_ONE / 2);
            4'd3:  res = RECIP_W'((RECIP_ONE + 2) / 3);
            4'd4:  res = RECIP_W'(RECIP_ONE / 4);
            4'd5:  res = RECIP_W'((RECIP_ONE + 4) / 5);
            4'd6:  res = RECIP_W'((RECIP_ONE + 5) / 6);
            4'd7:  res = RECIP_W'((RECIP_ONE + 6) / 7);
            4'd8:  res = RECIP_W'(RECIP_ONE / 8);
            4'd9:  res = RECIP_W'((RECIP_ONE + 8) / 9);
            4'd10: res = RECIP_W'((RECIP_ONE + 9) / 10);
            4'd11: res = RECIP_W'((RECIP_ONE + 10) / 11);
            4'd12: res = RECIP_W'((RECIP_ONE + 11) / 12);
            4'd13: res = RECIP_W'((RECIP_ONE + 12) / 13);
            4'd14: res = RECIP_W'((RECIP_ONE + 13) / 14);
            default: res = RECIP_W'((RECIP_ONE + 14) / 15);
        endcase
        return res;
    endfunction

endpackage

FILE: src/mgim_front.sv
// ----------------------------------------------------------------------------
// mgim_front: input stage of the multigrid index map
// Takes input words, classifies start commands and fine points, works out the
// per-item operands and hands them to the queue.
// ----------------------------------------------------------------------------
module mgim_front
    import mgim_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_s_tuser,
    input  t_cfg                i_cfg,
    input  t_q_stat             i_q_stat,
    output logic                o_push,
    output t_item               o_item
);

    logic                  r_valid;
    t_item                 r_item;
    t_item                 n_item;
    logic                  take;
    logic [2*SIZE_W-1:0]   area;

    assign o_push     = r_valid && !i_q_stat.full;
    assign o_s_tready = !r_valid || !i_q_stat.full;
    assign take       = i_s_tvalid && o_s_tready;
    assign o_item     = r_item;

    assign area = clamp_dim(i_cfg.rows) * clamp_dim(i_cfg.cols);

    always_comb begin
        n_item.start = (t_cmd'(i_s_tuser) == CMD_START);
        n_item.r1    = {1'b0, i_s_tdata[DIM_W-1:0]} + SIZE_W'(1);
        n_item.c1    = {1'b0, i_s_tdata[2*DIM_W-1:DIM_W]} + SIZE_W'(1);
        n_item.total = area[CNT_W-1:0];
        n_item.recip = factor_recip(i_cfg.factor);
        n_item.glast = eff_glast(i_cfg.grids);
        n_item.gid   = i_cfg.gid;
        n_item.procs = eff_procs(i_cfg.procs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: src/mgim_fifo.sv
// ----------------------------------------------------------------------------
// mgim_fifo: short queue between front and back parts
// Two entries of classified items, so that either side can stall alone.
// ----------------------------------------------------------------------------
module mgim_fifo
    import mgim_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

FILE: src/mgim_div.sv
// ----------------------------------------------------------------------------
// mgim_div: restoring divider for the point split
// Produces one quotient bit per cycle of the fine point total over the
// process count.
// ----------------------------------------------------------------------------
module mgim_div
    import mgim_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [CNT_W-1:0]   i_dividend,
    input  logic [PROCS_W-1:0] i_divisor,
    output logic               o_done,
    output logic [CNT_W-1:0]   o_quotient,
    output logic [REM_W-1:0]   o_remainder
);

    logic                  r_busy;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]      r_quo;
    logic [REM_W-1:0]      r_rem;
    logic [PROCS_W-1:0]    r_div;
    logic [PROCS_W-1:0]    rem_sh;
    logic [PROCS_W-1:0]    rem_sub;
    logic                  ge;

    // The partial remainder always stays below the divisor, so it fits in
    // one bit less than the divisor.
    assign rem_sh  = {r_rem, r_quo[CNT_W-1]};
    assign ge      = (rem_sh >= r_div);
    assign rem_sub = rem_sh - r_div;

    assign o_done      = r_busy && (r_cnt == '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_quo <= {r_quo[CNT_W-2:0], ge};
            r_rem <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        end
    end

endmodule

FILE: src/mgim_back.sv
// ----------------------------------------------------------------------------
// mgim_back: execution part of the multigrid index map
// Runs the split on start commands and walks the grids of each fine point,
// one result word per cycle unless stalled; keeps global and range counters.
// ----------------------------------------------------------------------------
module mgim_back
    import mgim_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_back_state            r_state;
    t_back_state            n_state;

    t_item                  r_cur;
    logic [SIZE_W-1:0]      r_qr;
    logic [SIZE_W-1:0]      r_qc;
    logic [K_W-1:0]         r_k;

    logic [CNT_W-1:0]       r_gc;
    logic [CNT_W-1:0]       r_fine;
    logic [PROCS_W-1:0]     r_rank;
    logic [CNT_W-1:0]       r_nfb;
    logic [CNT_W-1:0]       r_sq;
    logic [REM_W-1:0]       r_srem;

    logic                   r_ovalid;
    t_result                r_res;

    logic                   div_start;
    logic                   div_done;
    logic [CNT_W-1:0]       div_quo;
    logic [REM_W-1:0]       div_rem;

    logic                   out_free;
    logic                   emit;
    logic [SIZE_W+RECIP_W-1:0] prod_r;
    logic [SIZE_W+RECIP_W-1:0] prod_c;
    logic                   div_r;
    logic                   div_c;
    logic                   last;
    logic                   hit;
    logic [PROCS_W-1:0]     rank_inc;
    t_result                res_c;

    mgim_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_item.total),
        .i_divisor   (i_item.procs),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign out_free = !r_ovalid || i_ready;

    // A quotient is exact when the fraction left by the reciprocal product
    // is below the reciprocal itself.
    assign prod_r = r_qr * r_cur.recip;
    assign prod_c = r_qc * r_cur.recip;
    assign div_r  = (prod_r[RECIP_FRAC-1:0] < r_cur.recip);
    assign div_c  = (prod_c[RECIP_FRAC-1:0] < r_cur.recip);
    assign last   = !(div_r && div_c && (r_k != r_cur.glast));

    assign rank_inc = r_rank + PROCS_W'(1);
    assign hit      = last && (r_rank < r_cur.procs) && (r_fine == r_nfb);

    always_comb begin
        res_c.grid_row       = DIM_W'(r_qr - SIZE_W'(1));
        res_c.grid_col       = DIM_W'(r_qc - SIZE_W'(1));
        res_c.grid_number    = r_cur.gid + GID_W'(r_k);
        res_c.global_index   = r_gc;
        res_c.boundary_valid = hit;
        res_c.boundary_rank  = hit ? rank_inc : '0;
        res_c.boundary_value = hit ? (r_gc + CNT_W'(1)) : '0;
        res_c.last           = last;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = i_item.start ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free && last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pop     = !i_q_stat.empty;
                div_start = !i_q_stat.empty && i_item.start;
            end
            ST_EMIT: emit = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_gc     <= '0;
            r_fine   <= '0;
            r_rank   <= '0;
            r_nfb    <= '0;
            r_sq     <= '0;
            r_srem   <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop && !i_item.start) begin
                r_fine <= r_fine + CNT_W'(1);
            end
            if (r_state == ST_DIV && div_done) begin
                r_sq   <= div_quo;
                r_srem <= div_rem;
                r_gc   <= '0;
                r_fine <= '0;
                r_rank <= '0;
                r_nfb  <= div_quo + CNT_W'(div_rem != '0);
            end
            if (emit) begin
                r_gc <= r_gc + CNT_W'(1);
                if (hit) begin
                    r_rank <= rank_inc;
                    r_nfb  <= r_nfb + r_sq + CNT_W'(rank_inc < {1'b0, r_srem});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_item;
            r_qr  <= i_item.r1;
            r_qc  <= i_item.c1;
            r_k   <= '0;
        end else if (emit) begin
            r_qr <= prod_r[RECIP_FRAC +: SIZE_W];
            r_qc <= prod_c[RECIP_FRAC +: SIZE_W];
            r_k  <= r_k + K_W'(1);
        end
        if (emit) begin
            r_res <= res_c;
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

endmodule

FILE: src/multigrid_interleaved_index_map_core.sv
// ----------------------------------------------------------------------------
// multigrid_interleaved_index_map_core: interleaved numbering of one level
// An accepted fine point passes the front register and the queue; the back part
// then emits its result words (one to eight), one fine point at a time.
// A start command holds the back part while the 21-step divider runs.
// Synchronous active-low reset clears the counters and restores the defaults.
// ----------------------------------------------------------------------------
module multigrid_interleaved_index_map_core
    import mgim_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input words.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,  // fine_row, fine_col, zero pad
    input  logic                  s_axis_tuser,  // command
    // Result words.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,  // grid_row, grid_col, grid_number,
                                                 // global_index, boundary_rank,
                                                 // boundary_value, zero pad
    output logic                  m_axis_tuser,  // boundary_valid
    output logic                  m_axis_tlast,  // last
    // Register writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_item   w_front_item;
    t_item   w_head;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;
    t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.factor <= FACTOR_W'(2);
            r_cfg.rows   <= SIZE_W'(15);
            r_cfg.cols   <= SIZE_W'(15);
            r_cfg.grids  <= GRIDS_W'(1);
            r_cfg.gid    <= '0;
            r_cfg.procs  <= PROCS_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FACTOR: r_cfg.factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_ROWS:   r_cfg.rows   <= i_cfg_data[SIZE_W-1:0];
                CFG_COLS:   r_cfg.cols   <= i_cfg_data[SIZE_W-1:0];
                CFG_GRIDS:  r_cfg.grids  <= i_cfg_data[GRIDS_W-1:0];
                CFG_GID:    r_cfg.gid    <= i_cfg_data[GID_W-1:0];
                CFG_PROCS:  r_cfg.procs  <= i_cfg_data[PROCS_W-1:0];
                default: ;
            endcase
        end
    end

    mgim_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_cfg      (r_cfg),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_item     (w_front_item)
    );

    mgim_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_head),
        .o_stat  (w_q_stat)
    );

    mgim_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (w_res)
    );

    assign m_axis_tdata = M_DATA_W'({w_res.boundary_value, w_res.boundary_rank,
                                     w_res.global_index, w_res.grid_number,
                                     w_res.grid_col, w_res.grid_row});
    assign m_axis_tuser = w_res.boundary_valid;
    assign m_axis_tlast = w_res.last;

`ifndef SYNTHESIS
    a_boundary_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.boundary_valid |-> w_res.last)
        else $error("range boundary reported on a word that is not the last");

    a_boundary_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.boundary_valid |-> w_res.boundary_rank != '0)
        else $error("range boundary with zero rank");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("queue read while empty");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");
`endif

endmodule
